// ===== sv/mfsp_pkg.sv =====
// Shared types and constants for the MIDI file stream parser.
// No dependencies.
package mfsp_pkg;

	// Input item kinds
	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;

	// Result event kinds
	localparam logic [2:0] EV_HEADER  = 3'd0;
	localparam logic [2:0] EV_TRK_BEG = 3'd1;
	localparam logic [2:0] EV_TRK_END = 3'd2;
	localparam logic [2:0] EV_CHANNEL = 3'd3;
	localparam logic [2:0] EV_META    = 3'd4;
	localparam logic [2:0] EV_PAYLOAD = 3'd5;
	localparam logic [2:0] EV_DONE    = 3'd6;
	localparam logic [2:0] EV_ERROR   = 3'd7;

	// Error codes
	localparam logic [3:0] ERR_BAD_MTHD    = 4'd0;
	localparam logic [3:0] ERR_SHORT_HDR   = 4'd1;
	localparam logic [3:0] ERR_BAD_MTRK    = 4'd2;
	localparam logic [3:0] ERR_TLEN_CUT    = 4'd3;
	localparam logic [3:0] ERR_END_DELTA   = 4'd4;
	localparam logic [3:0] ERR_END_DATA    = 4'd5;
	localparam logic [3:0] ERR_END_MTYPE   = 4'd6;
	localparam logic [3:0] ERR_END_LEN     = 4'd7;
	localparam logic [3:0] ERR_END_PAYLOAD = 4'd8;
	localparam logic [3:0] ERR_RUNNING     = 4'd9;
	localparam logic [3:0] ERR_BAD_STATUS  = 4'd10;

	// Chunk ids
	localparam logic [31:0] ID_MTHD = 32'h4D54_6864;
	localparam logic [31:0] ID_MTRK = 32'h4D54_726B;

	// Status bytes and meta types
	localparam logic [7:0] ST_META      = 8'hFF;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
	localparam logic [8:0] META_EOT     = 9'h02F;
	localparam logic [8:0] META_TEMPO   = 9'h051;
	localparam logic [8:0] META_SYSEX   = 9'h100;

	// Result queue
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [31:0] tick;
		logic [7:0]  status_byte;
		logic [4:0]  channel;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic        has_second;
		logic [15:0] word_a;
		logic [31:0] word_b;
		logic [23:0] word_c;
		logic [3:0]  error_code;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

// ===== sv/mfsp_step.sv =====
// Parser state and per-byte decode; emits up to two results per input beat.
// Depends on mfsp_pkg.
module mfsp_step #(
	parameter int TICK_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        kind,
	input  logic [7:0]        byte_value,
	output mfsp_pkg::push_t   push
);

	localparam logic [3:0] PH_HID     = 4'd0;
	localparam logic [3:0] PH_HLEN    = 4'd1;
	localparam logic [3:0] PH_FMT     = 4'd2;
	localparam logic [3:0] PH_NTRK    = 4'd3;
	localparam logic [3:0] PH_DIV     = 4'd4;
	localparam logic [3:0] PH_HSKIP   = 4'd5;
	localparam logic [3:0] PH_TID     = 4'd6;
	localparam logic [3:0] PH_TLEN    = 4'd7;
	localparam logic [3:0] PH_DELTA   = 4'd8;
	localparam logic [3:0] PH_STATUS  = 4'd9;
	localparam logic [3:0] PH_DATA1   = 4'd10;
	localparam logic [3:0] PH_DATA2   = 4'd11;
	localparam logic [3:0] PH_MTYPE   = 4'd12;
	localparam logic [3:0] PH_SLEN    = 4'd13;
	localparam logic [3:0] PH_PAYLOAD = 4'd14;
	localparam logic [3:0] PH_IDLE    = 4'd15;

	logic [3:0]            ph_q, ph_d;
	logic [31:0]           bc_q, bc_d;
	logic [31:0]           acc_q, acc_d;
	logic [31:0]           hl_q, hl_d;
	logic [7:0]            rs_q, rs_d;
	logic [TICK_WIDTH-1:0] tt_q, tt_d;
	logic [15:0]           te_q, te_d;
	logic [15:0]           seen_q, seen_d;
	logic [8:0]            meta_q, meta_d;
	logic [7:0]            held_q, held_d;
	logic [31:0]           pl_q, pl_d;

	mfsp_pkg::res_t slot [2];
	logic [1:0]     cnt;
	logic [31:0]    tick32;
	logic [3:0]     end_code;

	assign tick32 = 32'(tt_q);

	function automatic mfsp_pkg::res_t err_res(input logic [3:0] code);
		mfsp_pkg::res_t r;
		r = '0;
		r.event_kind = mfsp_pkg::EV_ERROR;
		r.error_code = code;
		return r;
	endfunction

	function automatic logic two_data(input logic [7:0] st);
		return !(st[6:4] == 3'd4 || st[6:4] == 3'd5);
	endfunction

	always_comb begin
		case (ph_q) inside
			PH_HID: end_code = mfsp_pkg::ERR_BAD_MTHD;
			PH_HLEN, PH_FMT, PH_NTRK, PH_DIV, PH_HSKIP: end_code = mfsp_pkg::ERR_SHORT_HDR;
			PH_TID: end_code = mfsp_pkg::ERR_BAD_MTRK;
			PH_TLEN: end_code = mfsp_pkg::ERR_TLEN_CUT;
			PH_DELTA: end_code = mfsp_pkg::ERR_END_DELTA;
			PH_MTYPE: end_code = mfsp_pkg::ERR_END_MTYPE;
			PH_SLEN: end_code = mfsp_pkg::ERR_END_LEN;
			PH_PAYLOAD: end_code = mfsp_pkg::ERR_END_PAYLOAD;
			default: end_code = mfsp_pkg::ERR_END_DATA;
		endcase
	end

	always_comb begin : decode
		mfsp_pkg::res_t ev;
		logic           fin;
		logic           nxt_trk;
		logic [31:0]    bc_inc;

		ph_d    = ph_q;
		bc_d    = bc_q;
		acc_d   = acc_q;
		hl_d    = hl_q;
		rs_d    = rs_q;
		tt_d    = tt_q;
		te_d    = te_q;
		seen_d  = seen_q;
		meta_d  = meta_q;
		held_d  = held_q;
		pl_d    = pl_q;
		slot[0] = '0;
		slot[1] = '0;
		cnt     = 2'd0;
		ev      = '0;
		fin     = 1'b0;
		nxt_trk = 1'b0;
		bc_inc  = bc_q + 32'd1;

		if (accept) begin
			case (kind)
				mfsp_pkg::KIND_RESTART: begin
					ph_d   = PH_HID;
					bc_d   = '0;
					acc_d  = '0;
					hl_d   = '0;
					rs_d   = '0;
					tt_d   = '0;
					te_d   = '0;
					seen_d = '0;
					meta_d = '0;
					held_d = '0;
					pl_d   = '0;
				end
				mfsp_pkg::KIND_END: begin
					if (ph_q != PH_IDLE) begin
						slot[cnt[0]] = err_res(end_code);
						cnt = cnt + 2'd1;
						ph_d = PH_IDLE;
					end
				end
				mfsp_pkg::KIND_BYTE: begin
					unique case (ph_q)
						PH_HID, PH_TID: begin
							acc_d = {acc_q[23:0], byte_value};
							bc_d = bc_inc;
							if (bc_inc == 32'd4) begin
								if (ph_q == PH_HID && acc_d != mfsp_pkg::ID_MTHD) begin
									slot[cnt[0]] = err_res(mfsp_pkg::ERR_BAD_MTHD);
									cnt = cnt + 2'd1;
									ph_d = PH_IDLE;
								end else if (ph_q == PH_TID && acc_d != mfsp_pkg::ID_MTRK) begin
									slot[cnt[0]] = err_res(mfsp_pkg::ERR_BAD_MTRK);
									cnt = cnt + 2'd1;
									ph_d = PH_IDLE;
								end else if (ph_q == PH_HID) begin
									bc_d = '0;
									hl_d = '0;
									ph_d = PH_HLEN;
								end else begin
									bc_d = '0;
									acc_d = '0;
									ph_d = PH_TLEN;
								end
							end
						end
						PH_HLEN: begin
							hl_d = {hl_q[23:0], byte_value};
							bc_d = bc_inc;
							if (bc_inc == 32'd4) begin
								if (hl_d < 32'd6) begin
									slot[cnt[0]] = err_res(mfsp_pkg::ERR_SHORT_HDR);
									cnt = cnt + 2'd1;
									ph_d = PH_IDLE;
								end else begin
									bc_d = '0;
									acc_d = '0;
									ph_d = PH_FMT;
								end
							end
						end
						PH_FMT: begin
							acc_d = {16'd0, acc_q[7:0], byte_value};
							bc_d = bc_inc;
							if (bc_inc == 32'd2) begin
								bc_d = '0;
								te_d = '0;
								ph_d = PH_NTRK;
							end
						end
						PH_NTRK: begin
							te_d = {te_q[7:0], byte_value};
							bc_d = bc_inc;
							if (bc_inc == 32'd2) begin
								bc_d = '0;
								ph_d = PH_DIV;
							end
						end
						PH_DIV: begin
							if (bc_q == 32'd0) begin
								held_d = byte_value;
								bc_d = 32'd1;
							end else begin
								ev = '0;
								ev.event_kind = mfsp_pkg::EV_HEADER;
								ev.word_a = acc_q[15:0];
								ev.word_b = 32'(te_q);
								ev.word_c = {8'd0, held_q, byte_value};
								slot[cnt[0]] = ev;
								cnt = cnt + 2'd1;
								if (hl_q > 32'd6) begin
									bc_d = hl_q - 32'd6;
									ph_d = PH_HSKIP;
								end else begin
									nxt_trk = 1'b1;
								end
							end
						end
						PH_HSKIP: begin
							if (bc_q != 32'd0)
								bc_d = bc_q - 32'd1;
							if (bc_d == 32'd0)
								nxt_trk = 1'b1;
						end
						PH_TLEN: begin
							acc_d = {acc_q[23:0], byte_value};
							bc_d = bc_inc;
							if (bc_inc == 32'd4) begin
								tt_d = '0;
								rs_d = '0;
								ev = '0;
								ev.event_kind = mfsp_pkg::EV_TRK_BEG;
								ev.word_a = seen_q;
								ev.word_b = acc_d;
								slot[cnt[0]] = ev;
								cnt = cnt + 2'd1;
								acc_d = '0;
								ph_d = PH_DELTA;
							end
						end
						PH_DELTA: begin
							acc_d = {acc_q[24:0], byte_value[6:0]};
							if (!byte_value[7]) begin
								tt_d = tt_q + TICK_WIDTH'(acc_d);
								ph_d = PH_STATUS;
							end
						end
						PH_STATUS, PH_DATA1, PH_DATA2: begin
							if (ph_q == PH_STATUS && byte_value[7]) begin
								rs_d = byte_value;
								if (byte_value == mfsp_pkg::ST_META) begin
									ph_d = PH_MTYPE;
								end else if (byte_value == mfsp_pkg::ST_SYSEX
										|| byte_value == mfsp_pkg::ST_SYSEX_ESC) begin
									meta_d = mfsp_pkg::META_SYSEX;
									acc_d = '0;
									ph_d = PH_SLEN;
								end else if (byte_value > mfsp_pkg::ST_SYSEX) begin
									slot[cnt[0]] = err_res(mfsp_pkg::ERR_BAD_STATUS);
									cnt = cnt + 2'd1;
									ph_d = PH_IDLE;
								end else begin
									ph_d = PH_DATA1;
								end
							end else if (ph_q == PH_STATUS && rs_q == 8'd0) begin
								slot[cnt[0]] = err_res(mfsp_pkg::ERR_RUNNING);
								cnt = cnt + 2'd1;
								ph_d = PH_IDLE;
							end else if (ph_q != PH_DATA2 && two_data(rs_q)) begin
								held_d = byte_value;
								ph_d = PH_DATA2;
							end else begin
								if (ph_q != PH_DATA2)
									held_d = byte_value;
								ev = '0;
								ev.event_kind = mfsp_pkg::EV_CHANNEL;
								ev.tick = tick32;
								ev.status_byte = {rs_q[7:4], 4'd0};
								ev.channel = 5'd1 + {1'b0, rs_q[3:0]};
								ev.first_data = held_d;
								if (ph_q == PH_DATA2) begin
									ev.second_data = byte_value;
									ev.has_second = 1'b1;
								end
								slot[cnt[0]] = ev;
								cnt = cnt + 2'd1;
								acc_d = '0;
								ph_d = PH_DELTA;
							end
						end
						PH_MTYPE: begin
							meta_d = {1'b0, byte_value};
							acc_d = '0;
							ph_d = PH_SLEN;
						end
						PH_SLEN: begin
							acc_d = {acc_q[24:0], byte_value[6:0]};
							if (!byte_value[7]) begin
								pl_d = acc_d;
								acc_d = '0;
								bc_d = '0;
								if (pl_d == 32'd0)
									fin = 1'b1;
								else
									ph_d = PH_PAYLOAD;
							end
						end
						PH_PAYLOAD: begin
							if (meta_q == mfsp_pkg::META_TEMPO && bc_q < 32'd3)
								acc_d = {acc_q[23:0], byte_value};
							bc_d = bc_inc;
							if (meta_q != mfsp_pkg::META_EOT) begin
								ev = '0;
								ev.event_kind = mfsp_pkg::EV_PAYLOAD;
								ev.tick = tick32;
								ev.status_byte = rs_q;
								ev.first_data = byte_value;
								ev.word_a = 16'(meta_q);
								ev.word_b = pl_q;
								slot[cnt[0]] = ev;
								cnt = cnt + 2'd1;
							end
							if (bc_inc == pl_q)
								fin = 1'b1;
						end
						default: ;
					endcase
				end
				default: ;
			endcase

			if (fin) begin
				ev = '0;
				ev.tick = tick32;
				if (meta_q == mfsp_pkg::META_EOT) begin
					ev.event_kind = mfsp_pkg::EV_TRK_END;
					ev.word_a = seen_q;
					ev.word_b = tick32;
					nxt_trk = 1'b1;
				end else begin
					ev.event_kind = mfsp_pkg::EV_META;
					ev.status_byte = rs_q;
					ev.word_a = 16'(meta_q);
					ev.word_b = pl_d;
					if (meta_q == mfsp_pkg::META_TEMPO)
						ev.word_c = acc_d[23:0];
					rs_d = '0;
					acc_d = '0;
					ph_d = PH_DELTA;
				end
				slot[cnt[0]] = ev;
				cnt = cnt + 2'd1;
			end

			if (nxt_trk) begin
				if (seen_q == te_q) begin
					ev = '0;
					ev.event_kind = mfsp_pkg::EV_DONE;
					slot[cnt[0]] = ev;
					cnt = cnt + 2'd1;
					ph_d = PH_IDLE;
				end else begin
					seen_d = seen_q + 16'd1;
					bc_d = '0;
					acc_d = '0;
					ph_d = PH_TID;
				end
			end
		end

		if (cnt == 2'd1)
			slot[0].last = 1'b1;
		if (cnt == 2'd2)
			slot[1].last = 1'b1;
	end

	assign push.n  = cnt;
	assign push.r0 = slot[0];
	assign push.r1 = slot[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_HID;
			bc_q   <= '0;
			acc_q  <= '0;
			hl_q   <= '0;
			rs_q   <= '0;
			tt_q   <= '0;
			te_q   <= '0;
			seen_q <= '0;
			meta_q <= '0;
			held_q <= '0;
			pl_q   <= '0;
		end else begin
			ph_q   <= ph_d;
			bc_q   <= bc_d;
			acc_q  <= acc_d;
			hl_q   <= hl_d;
			rs_q   <= rs_d;
			tt_q   <= tt_d;
			te_q   <= te_d;
			seen_q <= seen_d;
			meta_q <= meta_d;
			held_q <= held_d;
			pl_q   <= pl_d;
		end
	end

endmodule

// ===== sv/mfsp_rfifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per beat.
// Depends on mfsp_pkg.
module mfsp_rfifo (
	input  logic            clk,
	input  logic            arst_n,
	input  mfsp_pkg::push_t push,
	output logic            room,
	output logic            valid,
	input  logic            ready,
	output mfsp_pkg::res_t  data
);

	mfsp_pkg::res_t             mem_q [mfsp_pkg::RQ_DEPTH];
	logic [mfsp_pkg::RQ_AW-1:0] wp_q, rp_q;
	logic [mfsp_pkg::RQ_AW:0]   cnt_q;
	logic                       pop;

	assign valid = cnt_q != '0;
	assign data  = mem_q[rp_q];
	assign pop   = valid && ready;
	assign room  = cnt_q <= (mfsp_pkg::RQ_AW + 1)'(mfsp_pkg::RQ_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wp_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wp_q + mfsp_pkg::RQ_AW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + mfsp_pkg::RQ_AW'(push.n);
			rp_q  <= rp_q + mfsp_pkg::RQ_AW'(pop);
			cnt_q <= cnt_q + (mfsp_pkg::RQ_AW + 1)'(push.n) - (mfsp_pkg::RQ_AW + 1)'(pop);
		end
	end

endmodule

// ===== sv/midi_file_stream_parser_core.sv =====
// Top level of the MIDI file stream parser: decode stage plus result queue.
// Depends on mfsp_pkg, mfsp_step, mfsp_rfifo.
//
// Takes one Standard MIDI File byte (or an end-of-input / restart marker) per
// beat and returns zero, one or two result beats per input. The decode stage
// updates all parser state in the cycle a beat is accepted and writes its
// results into a four-entry queue, which registers them before they reach the
// output. Input is accepted every cycle while the queue holds two or fewer
// results, so the sustained rate is one byte per cycle whenever the output
// drains at least as fast as results are produced; inputs that yield two
// results (header with no tracks, last payload byte, end of the last track)
// take two queue entries. Track time wraps at TICK_WIDTH bits; tick shows its
// low 32 bits.
module midi_file_stream_parser_core #(
	parameter int TICK_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  byte_value,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  event_kind,
	output logic [31:0] tick,
	output logic [7:0]  status_byte,
	output logic [4:0]  channel,
	output logic [7:0]  first_data,
	output logic [7:0]  second_data,
	output logic        has_second,
	output logic [15:0] word_a,
	output logic [31:0] word_b,
	output logic [23:0] word_c,
	output logic [3:0]  error_code,
	output logic        last
);

	mfsp_pkg::push_t push;
	mfsp_pkg::res_t  res;
	logic            room;

	assign item_ready = room;

	mfsp_step #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (item_valid && room),
		.kind      (kind),
		.byte_value(byte_value),
		.push      (push)
	);

	mfsp_rfifo u_rfifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.valid (result_valid),
		.ready (result_ready),
		.data  (res)
	);

	assign event_kind  = res.event_kind;
	assign tick        = res.tick;
	assign status_byte = res.status_byte;
	assign channel     = res.channel;
	assign first_data  = res.first_data;
	assign second_data = res.second_data;
	assign has_second  = res.has_second;
	assign word_a      = res.word_a;
	assign word_b      = res.word_b;
	assign word_c      = res.word_c;
	assign error_code  = res.error_code;
	assign last        = res.last;

endmodule
